[rtl/lfo_pkg.sv]
// shared types, constants and the quarter-wave sine table of the lfo waveform generator
package lfo_pkg;

  localparam int LEVEL_BITS       = 16;
  localparam int SINE_TABLE_DEPTH = 256;

  localparam int TIMER_W    = 22;
  localparam int FRAME_W    = 17;
  localparam int WAVE_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 22;

  localparam logic [TIMER_W-1:0] CYCLE_TIME_RESET = TIMER_W'(1000000);

  localparam int SINE_ADDR_W = $clog2(SINE_TABLE_DEPTH);
  localparam int Q30_W       = 31;

  // divider sizing: ratio numerator 2*n*full + c, sine numerator 8*d*t + c
  localparam int RATIO_NUM_W = TIMER_W + LEVEL_BITS + 2;
  localparam int SINE_NUM_W  = TIMER_W + SINE_ADDR_W + 4;
  localparam int DIV_NUM_W   = (RATIO_NUM_W > SINE_NUM_W) ? RATIO_NUM_W : SINE_NUM_W;
  localparam int DIV_DEN_W   = TIMER_W + 1;
  localparam int DIV_Q_W     = (LEVEL_BITS + 1 > SINE_ADDR_W + 3) ?
                               LEVEL_BITS + 1 : SINE_ADDR_W + 3;
  localparam int DIV_CNT_W   = $clog2(DIV_Q_W + 1);

  localparam logic [LEVEL_BITS-1:0] FULL_SCALE = '1;
  localparam logic [31:0]           Q30_ONE    = 32'h4000_0000;
  localparam longint unsigned       HALF_PI_Q30 = 64'd1686629713;

  // taylor term divisors (2n)(2n+1) for n = 1..6
  localparam longint unsigned TAYLOR_D3  = 64'd6;
  localparam longint unsigned TAYLOR_D5  = 64'd20;
  localparam longint unsigned TAYLOR_D7  = 64'd42;
  localparam longint unsigned TAYLOR_D9  = 64'd72;
  localparam longint unsigned TAYLOR_D11 = 64'd110;
  localparam longint unsigned TAYLOR_D13 = 64'd156;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_TRIANGLE = 3'd0,
    WAVE_SAW_UP   = 3'd1,
    WAVE_SAW_DOWN = 3'd2,
    WAVE_SQUARE   = 3'd3,
    WAVE_SINE     = 3'd4
  } wave_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CYCLE_TIME = 1'd0,
    CFG_WAVEFORM   = 1'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_CLAMP,
    ST_SHAPE,
    ST_LOAD,
    ST_DIV,
    ST_RATIO,
    ST_SINE,
    ST_DONE
  } lfo_state_e;

  typedef logic [Q30_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

  // taylor series through x^13 in q30, truncating, clamped to 0..1
  function automatic logic [Q30_W-1:0] quarter_sine(longint unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x    = (k * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / TAYLOR_D3;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / TAYLOR_D5;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / TAYLOR_D7;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / TAYLOR_D9;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / TAYLOR_D11;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / TAYLOR_D13;
    sum  = sum + longint'(term);
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    if (sum < 0) begin
      sum = 0;
    end
    return Q30_W'(sum);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      rom[k] = quarter_sine(longint'(k));
    end
    return rom;
  endfunction

  localparam sine_rom_t        SINE_ROM  = build_sine_rom();
  localparam logic [Q30_W-1:0] SINE_PEAK = quarter_sine(longint'(SINE_TABLE_DEPTH));

endpackage

[rtl/lfo_if.sv]
// item channels of the lfo waveform generator
interface lfo_in_if;
  logic                          valid;
  logic                          ready;
  logic [lfo_pkg::FRAME_W-1:0]   frame_time;

  modport source (output valid, output frame_time, input ready);
  modport sink   (input valid, input frame_time, output ready);
endinterface

interface lfo_out_if;
  logic                           valid;
  logic                           ready;
  logic [lfo_pkg::LEVEL_BITS-1:0] level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

[rtl/lfo_div.sv]
// restoring divider, one quotient bit per cycle
module lfo_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [lfo_pkg::DIV_NUM_W-1:0]   num_i,
  input  logic [lfo_pkg::DIV_DEN_W-1:0]   den_i,
  output logic                            done_o,
  output logic [lfo_pkg::DIV_Q_W-1:0]     quot_o
);

  logic                            busy_q, busy_d;
  logic [lfo_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [lfo_pkg::DIV_DEN_W-1:0]   rem_q, rem_d;
  logic [lfo_pkg::DIV_DEN_W-1:0]   den_q, den_d;
  logic [lfo_pkg::DIV_Q_W-1:0]     bits_q, bits_d;
  logic [lfo_pkg::DIV_DEN_W:0]     trial;

  // quotient bits replace numerator bits in the same shift register
  assign trial  = {rem_q, bits_q[lfo_pkg::DIV_Q_W-1]};
  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = bits_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    bits_d = bits_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = lfo_pkg::DIV_CNT_W'(lfo_pkg::DIV_Q_W);
      rem_d  = lfo_pkg::DIV_DEN_W'(num_i >> lfo_pkg::DIV_Q_W);
      den_d  = den_i;
      bits_d = num_i[lfo_pkg::DIV_Q_W-1:0];
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        if (trial >= {1'b0, den_q}) begin
          rem_d  = lfo_pkg::DIV_DEN_W'(trial - {1'b0, den_q});
          bits_d = {bits_q[lfo_pkg::DIV_Q_W-2:0], 1'b1};
        end else begin
          rem_d  = trial[lfo_pkg::DIV_DEN_W-1:0];
          bits_d = {bits_q[lfo_pkg::DIV_Q_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    bits_q <= bits_d;
  end

endmodule

[rtl/lfo_waveform_generator_top.sv]
// top level of the lfo waveform generator: phase timer, sequencer and waveform shaping
// usage
//   in_if carries one item per frame: frame_time, the microseconds since the
//   previous item. out_if returns exactly one item per input item: level, the
//   modulation depth as an unsigned fraction scaled by 2^LEVEL_BITS - 1. cycle_time
//   and waveform are set by the user on the cfg write port while idle, unenforced.
// item flow
//   in_if.ready is high only while the sequencer is idle. a triangle, sawtooth
//   or sine item goes through wrap, clamp, shape and divider load steps, then
//   the shared restoring divider, then one ratio step and, for the sine, one table
//   step. square and unused selectors go from the shape step straight to the
//   hand-over; a zero cycle time skips the divider. no new item is taken before the
//   last result is handed over; the next item can be taken in the cycle after that.
// reset
//   rst_ni clears the phase timer, loads the reset cycle time (1 s) and the triangle
//   wave, and empties the output register.
// back-pressure
//   the result sits in an output register; a new item may be accepted while it waits,
//   but its own result is held back until out_if.ready has taken the previous one.
module lfo_waveform_generator_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lfo_in_if.sink                           in_if,
  lfo_out_if.source                        out_if,
  input  logic                             cfg_we_i,
  input  logic [lfo_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lfo_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int TW = lfo_pkg::TIMER_W;
  localparam int LB = lfo_pkg::LEVEL_BITS;
  localparam int AW = lfo_pkg::SINE_ADDR_W;
  localparam int NW = lfo_pkg::DIV_NUM_W;
  localparam int QW = lfo_pkg::DIV_Q_W;
  localparam int PW = 32 + LB;

  lfo_pkg::lfo_state_e state_q, state_d;

  // configuration registers
  logic [TW-1:0]               cycle_q;
  logic [lfo_pkg::WAVE_W-1:0]  wave_q;

  // phase timer and working registers
  logic [TW-1:0]               phase_q, phase_d;
  logic [TW:0]                 tsum_q, tsum_d;
  logic [TW-1:0]               n_q, n_d;
  logic [QW-1:0]               quot_q, quot_d;
  logic [lfo_pkg::Q30_W-1:0]   sine_q, sine_d;
  logic                        neg_q, neg_d;
  logic [LB-1:0]               res_q, res_d;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic [LB-1:0]               out_level_q, out_level_d;

  // divider hookup
  logic                        div_start;
  logic [NW-1:0]               div_num;
  logic                        div_done;
  logic [QW-1:0]               div_quot;

  // combinational helpers
  logic [TW-1:0]               t_cur;
  logic [AW+1:0]               p_mod;
  logic [AW-1:0]               p_r;
  logic                        p_odd;
  logic [AW-1:0]               rom_idx;
  logic [31:0]                 sine_a;
  logic [PW-1:0]               sine_prod;
  logic [LB:0]                 sine_v;
  logic                        accept;

  assign t_cur  = tsum_q[TW-1:0];
  assign accept = in_if.valid && in_if.ready;

  assign in_if.ready  = (state_q == lfo_pkg::ST_IDLE);
  assign out_if.valid = out_valid_q;
  assign out_if.level = out_level_q;

  // sine phase index: rounded quotient is at most 4*d, so the low bits give it mod 4*d
  assign p_mod   = quot_q[AW+1:0];
  assign p_r     = p_mod[AW-1:0];
  assign p_odd   = p_mod[AW];
  assign rom_idx = p_odd ? AW'(-p_r) : p_r;

  // level = ((2^30 +/- s) * full + 2^30) >> 31, full taken as shift minus one
  assign sine_a    = neg_q ? (lfo_pkg::Q30_ONE - 32'(sine_q)) :
                             (lfo_pkg::Q30_ONE + 32'(sine_q));
  assign sine_prod = (PW'(sine_a) << LB) - PW'(sine_a) + PW'(lfo_pkg::Q30_ONE);
  assign sine_v    = sine_prod[PW-1:31];

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_q <= lfo_pkg::CYCLE_TIME_RESET;
      wave_q  <= lfo_pkg::WAVE_TRIANGLE;
    end else if (cfg_we_i) begin
      unique case (lfo_pkg::cfg_idx_e'(cfg_idx_i))
        lfo_pkg::CFG_CYCLE_TIME: cycle_q <= cfg_data_i[TW-1:0];
        lfo_pkg::CFG_WAVEFORM:   wave_q  <= cfg_data_i[lfo_pkg::WAVE_W-1:0];
        default:                 cycle_q <= cycle_q;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    tsum_d      = tsum_q;
    n_d         = n_q;
    quot_d      = quot_q;
    sine_d      = sine_q;
    neg_d       = neg_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_level_d = out_level_q;
    div_start   = 1'b0;
    div_num     = '0;

    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      lfo_pkg::ST_IDLE: begin
        if (accept) begin
          tsum_d  = {1'b0, phase_q} + (TW + 1)'(in_if.frame_time);
          state_d = lfo_pkg::ST_WRAP;
        end
      end
      lfo_pkg::ST_WRAP: begin
        // one wrap of the cycle time
        if (tsum_q > {1'b0, cycle_q}) begin
          tsum_d = tsum_q - {1'b0, cycle_q};
        end
        state_d = lfo_pkg::ST_CLAMP;
      end
      lfo_pkg::ST_CLAMP: begin
        // still beyond the cycle (long frame or shortened cycle): stick at the end
        if (tsum_q > {1'b0, cycle_q}) begin
          tsum_d  = {1'b0, cycle_q};
          phase_d = cycle_q;
        end else begin
          phase_d = tsum_q[TW-1:0];
        end
        state_d = lfo_pkg::ST_SHAPE;
      end
      lfo_pkg::ST_SHAPE: begin
        state_d = lfo_pkg::ST_LOAD;
        case (wave_q)
          lfo_pkg::WAVE_TRIANGLE: begin
            // rising half 2t, falling half 2(c - t)
            if ({t_cur, 1'b0} > {1'b0, cycle_q}) begin
              n_d = TW'({cycle_q - t_cur, 1'b0});
            end else begin
              n_d = TW'({t_cur, 1'b0});
            end
          end
          lfo_pkg::WAVE_SAW_UP:   n_d = t_cur;
          lfo_pkg::WAVE_SAW_DOWN: n_d = cycle_q - t_cur;
          lfo_pkg::WAVE_SINE:     n_d = t_cur;
          lfo_pkg::WAVE_SQUARE: begin
            res_d   = (t_cur > (cycle_q >> 1)) ? lfo_pkg::FULL_SCALE : '0;
            state_d = lfo_pkg::ST_DONE;
          end
          default: begin
            res_d   = '0;
            state_d = lfo_pkg::ST_DONE;
          end
        endcase
      end
      lfo_pkg::ST_LOAD: begin
        if (wave_q == lfo_pkg::WAVE_SINE) begin
          div_num = (NW'(n_q) << (AW + 3)) + NW'(cycle_q);
        end else begin
          div_num = (NW'(n_q) << (LB + 1)) - (NW'(n_q) << 1) + NW'(cycle_q);
        end
        if (cycle_q == '0) begin
          // zero cycle: phase counts as zero
          quot_d  = '0;
          state_d = lfo_pkg::ST_RATIO;
        end else begin
          div_start = 1'b1;
          state_d   = lfo_pkg::ST_DIV;
        end
      end
      lfo_pkg::ST_DIV: begin
        if (div_done) begin
          quot_d  = div_quot;
          state_d = lfo_pkg::ST_RATIO;
        end
      end
      lfo_pkg::ST_RATIO: begin
        if (wave_q == lfo_pkg::WAVE_SINE) begin
          // odd quadrants read the table backwards, the top entry is the peak
          if (p_odd && (p_r == '0)) begin
            sine_d = lfo_pkg::SINE_PEAK;
          end else begin
            sine_d = lfo_pkg::SINE_ROM[rom_idx];
          end
          neg_d   = p_mod[AW+1];
          state_d = lfo_pkg::ST_SINE;
        end else begin
          res_d   = (quot_q > QW'(lfo_pkg::FULL_SCALE)) ? lfo_pkg::FULL_SCALE :
                                                          quot_q[LB-1:0];
          state_d = lfo_pkg::ST_DONE;
        end
      end
      lfo_pkg::ST_SINE: begin
        res_d   = (sine_v > (LB + 1)'(lfo_pkg::FULL_SCALE)) ? lfo_pkg::FULL_SCALE :
                                                              sine_v[LB-1:0];
        state_d = lfo_pkg::ST_DONE;
      end
      lfo_pkg::ST_DONE: begin
        // hand over once the output register is free
        if (!out_valid_d) begin
          out_valid_d = 1'b1;
          out_level_d = res_q;
          state_d     = lfo_pkg::ST_IDLE;
        end
      end
      default: state_d = lfo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfo_pkg::ST_IDLE;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tsum_q      <= tsum_d;
    n_q         <= n_d;
    quot_q      <= quot_d;
    sine_q      <= sine_d;
    neg_q       <= neg_d;
    res_q       <= res_d;
    out_level_q <= out_level_d;
  end

  lfo_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   ({cycle_q, 1'b0}),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

endmodule

[rtl/lfo_chk.sv]
// port-level checker of the lfo waveform generator and its bind
module lfo_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [lfo_pkg::LEVEL_BITS-1:0]   out_level_i
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  // and keeps its level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_level_i))
    else $error("result level changed while stalled");

  // an accepted item keeps the block busy for the wrap and clamp steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i ##1 !in_ready_i)
    else $error("input taken again while an item is at work");

  // no result is shown during reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind lfo_waveform_generator_top lfo_chk u_lfo_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_level_i (out_if.level)
);
